[hw/rtl/key_matrix_midi_note_encoder_top_assert.svh]
// Assertion macros for the key matrix MIDI encoder RTL.
// Included by kmme_back, which checks its own control logic; no other dependencies.
`ifndef KEY_MATRIX_MIDI_NOTE_ENCODER_TOP_ASSERT_SVH
`define KEY_MATRIX_MIDI_NOTE_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KMME_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("kmme assertion failed: same-cycle check");

// Next-cycle implication, checked out of reset.
`define KMME_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("kmme assertion failed: next-cycle check");

`endif

[hw/rtl/kmme_pkg.sv]
// Shared types, constants and helpers for the key matrix MIDI note encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package kmme_pkg;

  localparam int ROWS      = 4;
  localparam int ROW_W     = 2;
  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COLS      = 8;
  localparam int COL_IDX_W = 3;

  localparam int OCT_W  = 3;
  localparam int VEL_W  = 7;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] NOTE_ON_STATUS  = 8'h91;
  localparam logic [BYTE_W-1:0] NOTE_OFF_STATUS = 8'h81;
  localparam logic [BYTE_W-1:0] NOTE_BASE       = 8'd5;

  localparam logic [OCT_W-1:0] OCT_RESET = 3'd4;
  localparam logic [VEL_W-1:0] VEL_RESET = 7'd127;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_SHIFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_VELOCITY = 2'd1;

  // Job queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COLS-1:0]  bits;
    logic [COLS-1:0]  changed;
  } job_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [COL_IDX_W-1:0] lowest_set(input logic [COLS-1:0] m);
    logic [COL_IDX_W-1:0] idx;
    idx = '0;
    for (int i = COLS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = COL_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[hw/rtl/key_matrix_midi_note_encoder_top.sv]
// Top level of the key matrix MIDI note encoder: config registers, front end,
// job queue and byte emitter. Depends on kmme_pkg, kmme_front, kmme_queue, kmme_back.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------------
//   in_      | in  | in_valid / in_ready  | in_row[1:0], in_column_bits[7:0]
//   out_     | out | out_valid / out_ready| out_midi_byte[7:0], out_last_byte
//   cfg_     | in  | cfg_we (no wait)     | cfg_index[1:0], cfg_wdata[6:0]
//
// Flow: a row beat is classified in the cycle it is accepted and enters the
// job queue at that edge; the emitter then loads the job and emits 3*k bytes
// for k changed keys (up to 24 bytes per row), so the first byte shows after
// the queue, the emitter load and the output register. The emitter's
// one-byte-per-cycle walk over the changed bits, while out_ready does not
// stall it, sets the rate; the two-entry job queue lets new rows be taken
// while a row is still being emitted. Reset is synchronous, active low: stored
// rows clear to zero, octave_shift to 4, note_velocity to 127.
// A stalled out_ready holds the output register; a full queue drops in_ready.
`timescale 1ns / 1ps

module key_matrix_midi_note_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kmme_pkg::ROW_W-1:0]    in_row,
  input  logic [kmme_pkg::COLS-1:0]     in_column_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kmme_pkg::BYTE_W-1:0]   out_midi_byte,
  output logic                          out_last_byte,
  input  logic                          cfg_we,
  input  logic [kmme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmme_pkg::VEL_W-1:0]    cfg_wdata
);

  logic [kmme_pkg::OCT_W-1:0] octave_shift_r;
  logic [kmme_pkg::VEL_W-1:0] note_velocity_r;

  logic           push_valid, push_ready;
  kmme_pkg::job_t push_job;
  logic           pop_valid, pop_ready;
  kmme_pkg::job_t pop_job;

  // Config: user writes only while the block is idle (unenforced); drops unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_shift_r  <= kmme_pkg::OCT_RESET;
      note_velocity_r <= kmme_pkg::VEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmme_pkg::REG_OCTAVE_SHIFT:  octave_shift_r  <= cfg_wdata[kmme_pkg::OCT_W-1:0];
        kmme_pkg::REG_NOTE_VELOCITY: note_velocity_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Classify rows and queue the ones that changed.
  kmme_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row         (in_row),
    .in_column_bits (in_column_bits),
    .push_valid     (push_valid),
    .push_job       (push_job),
    .push_ready     (push_ready)
  );

  // Hold pending jobs so each side can stall on its own.
  kmme_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  // Emit status, note and velocity for each changed key, lowest column first.
  kmme_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .octave_shift  (octave_shift_r),
    .note_velocity (note_velocity_r),
    .pop_valid     (pop_valid),
    .pop_job       (pop_job),
    .pop_ready     (pop_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_midi_byte (out_midi_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

[hw/rtl/kmme_front.sv]
// Front end: accepts scanned rows, compares them with the stored row bits and
// queues a job for every row that changed. Depends on kmme_pkg.
`timescale 1ns / 1ps

module kmme_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kmme_pkg::ROW_W-1:0]   in_row,
  input  logic [kmme_pkg::COLS-1:0]    in_column_bits,
  output logic                         push_valid,
  output kmme_pkg::job_t               push_job,
  input  logic                         push_ready
);

  logic [kmme_pkg::COLS-1:0]      prev_bits_r [kmme_pkg::ROWS];
  logic [kmme_pkg::ROW_IDX_W-1:0] row_idx;
  logic                           row_ok;
  logic                           accept;
  logic [kmme_pkg::COLS-1:0]      prev_sel;
  logic [kmme_pkg::COLS-1:0]      changed;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign row_idx  = kmme_pkg::ROW_IDX_W'(in_row);
  assign row_ok   = ({1'b0, in_row} < 3'(kmme_pkg::ROWS));
  assign prev_sel = row_ok ? prev_bits_r[row_idx] : '0;
  assign changed  = in_column_bits ^ prev_sel;

  assign push_valid       = accept && row_ok && (changed != '0);
  assign push_job.row     = in_row;
  assign push_job.bits    = in_column_bits;
  assign push_job.changed = changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < kmme_pkg::ROWS; r++) begin
        prev_bits_r[r] <= '0;
      end
    end else if (accept && row_ok) begin
      prev_bits_r[row_idx] <= in_column_bits;
    end
  end

endmodule

[hw/rtl/kmme_queue.sv]
// Short job queue that decouples the front end from the byte emitter.
// Depends on kmme_pkg for the job type and depth.
`timescale 1ns / 1ps

module kmme_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  kmme_pkg::job_t push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output kmme_pkg::job_t pop_job,
  input  logic           pop_ready
);

  kmme_pkg::job_t                 slot_r [kmme_pkg::QDEPTH];
  logic [kmme_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [kmme_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [kmme_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                           do_push, do_pop;

  assign push_ready = (count_r != kmme_pkg::QCNT_W'(kmme_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [kmme_pkg::QPTR_W-1:0] bump(input logic [kmme_pkg::QPTR_W-1:0] p);
    logic [kmme_pkg::QPTR_W-1:0] q;
    q = (p == kmme_pkg::QPTR_W'(kmme_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    return q;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hw/rtl/kmme_back.sv]
// Back end: walks the changed bits of one job, lowest first, and emits three
// MIDI bytes per changed key through an output register. Depends on kmme_pkg.
`timescale 1ns / 1ps
`include "key_matrix_midi_note_encoder_top_assert.svh"

module kmme_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [kmme_pkg::OCT_W-1:0]   octave_shift,
  input  logic [kmme_pkg::VEL_W-1:0]   note_velocity,
  input  logic                         pop_valid,
  input  kmme_pkg::job_t               pop_job,
  output logic                         pop_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kmme_pkg::BYTE_W-1:0]  out_midi_byte,
  output logic                         out_last_byte
);

  localparam logic [1:0] PH_STATUS = 2'd0;
  localparam logic [1:0] PH_NOTE   = 2'd1;
  localparam logic [1:0] PH_VEL    = 2'd2;

  logic                          busy_r, busy_nxt;
  logic [1:0]                    phase_r, phase_nxt;
  logic [kmme_pkg::COLS-1:0]     mask_r, mask_nxt;
  logic [kmme_pkg::COLS-1:0]     bits_r;
  logic [kmme_pkg::ROW_W-1:0]    row_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [kmme_pkg::BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          can_emit;
  logic                          last_emit;
  logic [kmme_pkg::COL_IDX_W-1:0] bit_idx;
  logic [kmme_pkg::COLS-1:0]     bit_sel;
  logic [kmme_pkg::COLS-1:0]     mask_rest;
  logic [kmme_pkg::BYTE_W-1:0]   note;

  assign pop_ready     = !busy_r;
  assign out_valid     = out_valid_r;
  assign out_midi_byte = out_byte_r;
  assign out_last_byte = out_last_r;

  assign can_emit  = busy_r && (!out_valid_r || out_ready);
  assign bit_idx   = kmme_pkg::lowest_set(mask_r);
  assign bit_sel   = kmme_pkg::COLS'(1) << bit_idx;
  assign mask_rest = mask_r & ~bit_sel;
  assign last_emit = can_emit && (phase_r == PH_VEL) && (mask_rest == '0);
  // note = 5 + 12*octave + 8*row + column
  assign note = kmme_pkg::NOTE_BASE
              + {2'b00, octave_shift, 3'b000}
              + {3'b000, octave_shift, 2'b00}
              + {3'b000, row_r, bit_idx};

  always_comb begin
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (!busy_r) begin
      if (pop_valid) begin
        busy_nxt  = 1'b1;
        phase_nxt = PH_STATUS;
        mask_nxt  = pop_job.changed;
      end
    end else if (can_emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      unique case (phase_r)
        PH_STATUS: begin
          out_byte_nxt = bits_r[bit_idx] ? kmme_pkg::NOTE_ON_STATUS
                                         : kmme_pkg::NOTE_OFF_STATUS;
          phase_nxt    = PH_NOTE;
        end
        PH_NOTE: begin
          out_byte_nxt = note;
          phase_nxt    = PH_VEL;
        end
        PH_VEL: begin
          out_byte_nxt = {1'b0, note_velocity};
          out_last_nxt = (mask_rest == '0);
          mask_nxt     = mask_rest;
          phase_nxt    = PH_STATUS;
          busy_nxt     = (mask_rest != '0);
        end
        default: begin
          phase_nxt = PH_STATUS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_STATUS;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (!busy_r && pop_valid) begin
      bits_r <= pop_job.bits;
      row_r  <= pop_job.row;
    end
  end

  `KMME_ASSERT_NOW(a_idle_at_status, clk, rst_n, !busy_r, phase_r == PH_STATUS)
  `KMME_ASSERT_NOW(a_busy_has_work, clk, rst_n, busy_r, mask_r != '0)
  `KMME_ASSERT_NEXT(a_last_frees, clk, rst_n, last_emit, !busy_r && out_valid_r && out_last_r)

endmodule

[tb/sv/tb_key_matrix_midi_note_encoder_top.sv]
// Self-checking bench for key_matrix_midi_note_encoder_top: directed rows, then random scans.
// Predicts MIDI bytes from a mirror of stored rows and registers or the directed table; needs kmme_pkg.
`timescale 1ns / 1ps

module tb_key_matrix_midi_note_encoder_top;
  import kmme_pkg::*;

  localparam int        HALF_PERIOD  = 6;
  localparam int        MAX_WAIT     = 18;
  localparam int        SETTLE       = 40;      // cycles past the last byte before a write
  localparam int        RANDOM_ROWS  = 450;
  localparam longint    RUN_LIMIT_NS = 20_000_000;

  // Indexes past the register list; writes there must be dropped by the block.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {STEP_ROW, STEP_CFG} step_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_TYPED} step_check_e;

  typedef struct packed {
    step_kind_e           kind;
    step_check_e          chk;
    logic [ROW_W-1:0]     row;
    logic [COLS-1:0]      keys;
    logic [CFG_IDX_W-1:0] idx;
    logic [VEL_W-1:0]     data;
    logic [BYTE_W-1:0]    status;
    logic [BYTE_W-1:0]    note;
    logic [VEL_W-1:0]     vel;
  } plan_step_t;

  typedef struct packed {
    logic [BYTE_W-1:0] midi_byte;
    logic              last_byte;
  } note_beat_t;

  // ------------------------------------------------------------------------
  // Clock and DUT hookup. Every input starts at a known value.
  // ------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ROW_W-1:0]     in_row = '0;
  logic [COLS-1:0]      in_column_bits = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_midi_byte;
  logic                 out_last_byte;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VEL_W-1:0]     cfg_wdata = '0;

  always #HALF_PERIOD clk = ~clk;

  key_matrix_midi_note_encoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row         (in_row),
    .in_column_bits (in_column_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_midi_byte  (out_midi_byte),
    .out_last_byte  (out_last_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // ------------------------------------------------------------------------
  // Mirror of the block: stored key rows and the two registers.
  // ------------------------------------------------------------------------
  logic [COLS-1:0]  held_keys [0:ROWS-1];
  logic [OCT_W-1:0] octave_mirror = OCT_RESET;
  logic [VEL_W-1:0] velocity_mirror = VEL_RESET;

  note_beat_t pending_beats [$];
  plan_step_t plan [$];

  int rows_sent    = 0;
  int beats_seen   = 0;
  int cfg_writes   = 0;
  int silent_rows  = 0;
  int fail_count   = 0;
  int in_mode      = 1;   // 0: back-to-back beats, otherwise random gaps
  int out_mode     = 1;   // 0: always ready, otherwise random stalls

  initial begin
    for (int r = 0; r < ROWS; r++) held_keys[r] = '0;
  end

  // Expected byte stream for one scanned row. With emit low, only update the
  // stored row (the directed table then supplies the bytes itself).
  function automatic void encode_row(input logic [ROW_W-1:0] r, input logic [COLS-1:0] keys,
                                     input bit emit);
    logic [COLS-1:0]   changed;
    int                top;
    int                note_val;
    note_beat_t        beat;
    changed = keys ^ held_keys[r];
    held_keys[r] = keys;
    top = -1;
    for (int k = 0; k < COLS; k++) if (changed[k]) top = k;
    if (!emit || top < 0) return;
    for (int k = 0; k < COLS; k++) begin
      if (changed[k]) begin
        note_val = 5 + 12 * int'(octave_mirror) + 8 * int'(r) + k;
        beat.midi_byte = keys[k] ? NOTE_ON_STATUS : NOTE_OFF_STATUS;
        beat.last_byte = 1'b0;
        pending_beats.push_back(beat);
        beat.midi_byte = note_val[BYTE_W-1:0];
        pending_beats.push_back(beat);
        beat.midi_byte = {1'b0, velocity_mirror};
        beat.last_byte = (k == top);
        pending_beats.push_back(beat);
      end
    end
  endfunction

  function automatic int draw_wait(input int mode);
    if (mode == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Random row content: mostly one or two keys pressed or released against
  // the stored row, some noise, some all-on or all-off rows, some repeats that must stay silent.
  function automatic logic [COLS-1:0] pick_keys(input logic [ROW_W-1:0] r);
    logic [COLS-1:0] keys;
    logic [31:0]     raw;
    keys = held_keys[r];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        keys[$urandom_range(0, COLS - 1)] ^= 1'b1;
        if ($urandom_range(0, 1)) keys[$urandom_range(0, COLS - 1)] ^= 1'b1;
      end
      6, 7: begin
        raw = $urandom();
        keys = raw[COLS-1:0];
      end
      8: keys = held_keys[r];
      default: keys = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return keys;
  endfunction

  // ------------------------------------------------------------------------
  // Directed plan builders
  // ------------------------------------------------------------------------
  function automatic void plan_row(input step_check_e chk, input logic [ROW_W-1:0] r,
                                   input logic [COLS-1:0] keys, input logic [BYTE_W-1:0] st,
                                   input logic [BYTE_W-1:0] note, input logic [VEL_W-1:0] vel);
    plan_step_t s;
    s = '0;
    s.kind = STEP_ROW;
    s.chk = chk;
    s.row = r;
    s.keys = keys;
    s.status = st;
    s.note = note;
    s.vel = vel;
    plan.push_back(s);
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [VEL_W-1:0] d);
    plan_step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.chk = CHK_MODEL;
    s.idx = idx;
    s.data = d;
    plan.push_back(s);
  endfunction

  // ------------------------------------------------------------------------
  // Drivers. Every task is entered right after a rising edge; in_valid stays
  // high across back-to-back beats and is lowered only when a gap follows.
  // ------------------------------------------------------------------------
  task automatic send_row(input logic [ROW_W-1:0] r, input logic [COLS-1:0] keys,
                          input bit emit);
    int gap;
    gap = draw_wait(in_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row <= r;
    in_column_bits <= keys;
    do @(posedge clk); while (!in_ready);
    // Beat accepted at this edge: predict now, in acceptance order.
    if (keys == held_keys[r]) silent_rows++;
    encode_row(r, keys, emit);
    rows_sent++;
  endtask

  // Drop valid, wait for every expected byte, then let a silent row retire.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VEL_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_OCTAVE_SHIFT) octave_mirror = d[OCT_W-1:0];
    else if (idx == REG_NOTE_VELOCITY) velocity_mirror = d;
    cfg_writes++;
  endtask

  function automatic void push_typed(input plan_step_t s);
    note_beat_t beat;
    beat.last_byte = 1'b0;
    beat.midi_byte = s.status;
    pending_beats.push_back(beat);
    beat.midi_byte = s.note;
    pending_beats.push_back(beat);
    beat.midi_byte = {1'b0, s.vel};
    beat.last_byte = 1'b1;
    pending_beats.push_back(beat);
  endfunction

  // ------------------------------------------------------------------------
  // Result side: stall at random, check every accepted byte against the
  // oldest expectation.
  // ------------------------------------------------------------------------
  initial begin : midi_sink
    int         stall;
    note_beat_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(out_mode);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats_seen++;
      if (pending_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected byte %02h last=%0b", $realtime, out_midi_byte,
                   out_last_byte);
      end else begin
        want = pending_beats.pop_front();
        if (out_midi_byte !== want.midi_byte || out_last_byte !== want.last_byte) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] byte mismatch: expected %02h last=%0b, got %02h last=%0b",
                     $realtime, want.midi_byte, want.last_byte, out_midi_byte, out_last_byte);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin : stimulus
    plan_step_t       s;
    int               phase_rows;
    int               random_done;
    logic [ROW_W-1:0] r;
    logic [VEL_W-1:0] d;

    // Reset defaults are octave 4 (base note 53) and velocity 127.
    plan_row(CHK_TYPED,  2'd0, 8'h01, NOTE_ON_STATUS,  8'd53, 7'd127);
    plan_row(CHK_SILENT, 2'd0, 8'h01, '0, '0, '0);                       // no change
    plan_row(CHK_TYPED,  2'd0, 8'h00, NOTE_OFF_STATUS, 8'd53, 7'd127);
    plan_row(CHK_TYPED,  2'd3, 8'h80, NOTE_ON_STATUS,  8'd84, 7'd127);
    plan_row(CHK_MODEL,  2'd1, 8'hFF, '0, '0, '0);                       // eight keys at once
    plan_row(CHK_MODEL,  2'd1, 8'h00, '0, '0, '0);
    plan_row(CHK_MODEL,  2'd2, 8'hA5, '0, '0, '0);
    plan_row(CHK_MODEL,  2'd2, 8'h5A, '0, '0, '0);
    // Octave field is three bits wide: the upper data bits must be masked.
    plan_cfg(REG_OCTAVE_SHIFT, 7'h7F);
    plan_cfg(REG_NOTE_VELOCITY, 7'd0);
    plan_row(CHK_TYPED,  2'd3, 8'h00, NOTE_OFF_STATUS, 8'd120, 7'd0);    // highest note
    plan_row(CHK_MODEL,  2'd3, 8'hFF, '0, '0, '0);
    plan_row(CHK_SILENT, 2'd3, 8'hFF, '0, '0, '0);
    plan_cfg(REG_OCTAVE_SHIFT, 7'd0);
    plan_cfg(REG_NOTE_VELOCITY, 7'd127);
    plan_cfg(REG_SPARE_2, 7'h55);                                        // ignored
    plan_cfg(REG_SPARE_3, 7'h2A);                                        // ignored
    plan_row(CHK_TYPED,  2'd0, 8'h01, NOTE_ON_STATUS,  8'd5, 7'd127);    // lowest note
    plan_row(CHK_MODEL,  2'd0, 8'h80, '0, '0, '0);
    plan_row(CHK_TYPED,  2'd1, 8'h01, NOTE_ON_STATUS,  8'd13, 7'd127);
    plan_cfg(REG_OCTAVE_SHIFT, 7'd3);
    plan_cfg(REG_NOTE_VELOCITY, 7'h55);
    plan_row(CHK_MODEL,  2'd2, 8'hFF, '0, '0, '0);
    plan_row(CHK_MODEL,  2'd2, 8'h00, '0, '0, '0);
    plan_row(CHK_MODEL,  2'd1, 8'hFE, '0, '0, '0);
    plan_cfg(REG_NOTE_VELOCITY, 7'h2A);
    plan_row(CHK_MODEL,  2'd0, 8'h7F, '0, '0, '0);
    plan_row(CHK_SILENT, 2'd2, 8'h00, '0, '0, '0);
    plan_row(CHK_MODEL,  2'd3, 8'h3C, '0, '0, '0);

    // Hold reset low, then release it for good.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; register writes wait for the block to go idle.
    foreach (plan[i]) begin
      s = plan[i];
      if (s.kind == STEP_CFG) begin
        settle_idle();
        write_reg(s.idx, s.data);
      end else if (s.chk == CHK_TYPED) begin
        send_row(s.row, s.keys, 1'b0);
        push_typed(s);
      end else begin
        // Silent rows go through the predictor too; it queues nothing for them.
        send_row(s.row, s.keys, 1'b1);
      end
    end

    // Random phases: fresh register values and idle pattern for each one.
    random_done = 0;
    while (random_done < RANDOM_ROWS) begin
      settle_idle();
      case ($urandom_range(0, 3))
        0:       d = 7'd0;
        1:       d = 7'h7F;
        default: d = 7'($urandom_range(0, 127));
      endcase
      write_reg(REG_OCTAVE_SHIFT, d);
      case ($urandom_range(0, 3))
        0:       d = 7'd0;
        1:       d = 7'd127;
        default: d = 7'($urandom_range(0, 127));
      endcase
      write_reg(REG_NOTE_VELOCITY, d);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  7'($urandom_range(0, 127)));
      in_mode = $urandom_range(0, 2);
      out_mode = $urandom_range(0, 2);
      phase_rows = $urandom_range(30, 60);
      if (phase_rows > RANDOM_ROWS - random_done) phase_rows = RANDOM_ROWS - random_done;
      repeat (phase_rows) begin
        r = ROW_W'($urandom_range(0, ROWS - 1));
        send_row(r, pick_keys(r), 1'b1);
        random_done++;
      end
    end

    // Drain: nothing left to expect, then a quiet tail for stray bytes.
    settle_idle();

    $display("Sent %0d row scans (%0d silent), checked %0d MIDI bytes, %0d register writes.",
             rows_sent, silent_rows, beats_seen, cfg_writes);
    $display("Mismatches or stray bytes: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d bytes still expected", pending_beats.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
